// ===== hdl/strict_priority_task_queues_assert.svh =====
// Assertion shorthands for the strict-priority task queues.
// Each expects clk_i and rst_ni in scope.
`ifndef STRICT_PRIORITY_TASK_QUEUES_ASSERT_SVH
`define STRICT_PRIORITY_TASK_QUEUES_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ENQ   = 3'd0,
    ST_DROP  = 3'd1,
    ST_DEQ   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FLUSH = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [1:0]        priority_req;
    logic [FieldW-1:0] task_function;
    logic [FieldW-1:0] task_argument;
  } spq_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        served_level;
    logic [FieldW-1:0] out_function;
    logic [FieldW-1:0] out_argument;
  } spq_out_t;

endpackage

// ===== hdl/spq_ram.sv =====
module spq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/strict_priority_task_queues.sv =====
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-----------------------------------
// in      | input     | in_valid_i/in_stall_o | in_data_i  (op, level, func, arg)
// out     | output    | out_valid_o/out_stall_i| out_data_o (status, level, func, arg)
//
// Enqueue, flush, an empty dequeue and the reserved op load the output register at accept.
// A dequeue that finds a task loads its result from the task store's registered read port.
// One transaction is in flight at a time; the result sits in an output register.
// Reset clears pointers, counts and control at once; the task store is not cleared.
// in_stall_o is high while a dequeue read is pending or while a held result is stalled.
module strict_priority_task_queues #(
  parameter int unsigned PRIO_LEVELS = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spq_pkg::spq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);

  import spq_pkg::*;

  `include "strict_priority_task_queues_assert.svh"

  localparam int unsigned LvlW   = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Slots  = PRIO_LEVELS * QUEUE_DEPTH;
  localparam int unsigned AddrW  = $clog2(Slots);
  localparam int unsigned WordW  = 2 * HANDLE_BITS;

  // Sequencer: idle, or waiting for task store read data.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  // Per-level FIFO bookkeeping.
  logic [PtrW-1:0] head_q [PRIO_LEVELS];
  logic [PtrW-1:0] head_d [PRIO_LEVELS];
  logic [PtrW-1:0] tail_q [PRIO_LEVELS];
  logic [PtrW-1:0] tail_d [PRIO_LEVELS];
  logic [CntW-1:0] count_q [PRIO_LEVELS];
  logic [CntW-1:0] count_d [PRIO_LEVELS];

  logic             out_valid_q, out_valid_d;
  spq_out_t         out_q, out_d;
  logic [LvlW-1:0]  served_q, served_d;

  logic             in_accept;
  logic             lvl_ok;
  logic [LvlW-1:0]  lvl_idx;
  logic             is_enq, is_deq, is_flush;
  logic             enq_ok;
  logic [PRIO_LEVELS-1:0] level_nonempty;
  logic [PRIO_LEVELS-1:0] eligible;
  logic [LvlW-1:0]  sel_lvl;
  logic             deq_hit;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  function automatic logic [AddrW-1:0] slot_addr(logic [LvlW-1:0] lvl, logic [PtrW-1:0] ptr);
    logic [AddrW-1:0] base;
    base = AddrW'(AddrW'(lvl) * AddrW'(QUEUE_DEPTH));
    return base + AddrW'(ptr);
  endfunction

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Handshake: one transaction at a time; the output slot must be free after this edge.
  assign in_stall_o = (state_q == S_READ) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_enq   = (in_data_i.func == OP_ENQ);
  assign is_deq   = (in_data_i.func == OP_DEQ);
  assign is_flush = (in_data_i.func == OP_FLUSH);

  assign lvl_ok  = (32'(in_data_i.priority_req) < PRIO_LEVELS);
  assign lvl_idx = LvlW'(in_data_i.priority_req);

  // Eligible levels for a dequeue, then the highest one wins.
  always_comb begin
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      level_nonempty[l] = (count_q[l] != '0);
      eligible[l] = level_nonempty[l] && lvl_ok && (l >= int'(in_data_i.priority_req));
    end
  end

  always_comb begin
    sel_lvl = '0;
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      if (eligible[l]) begin
        sel_lvl = LvlW'(l);
      end
    end
  end

  assign deq_hit = is_deq && (|eligible);
  assign enq_ok  = is_enq && lvl_ok && (count_q[lvl_idx] != CntW'(QUEUE_DEPTH));

  // Task store ports: enqueue writes at the tail, dequeue reads at the head.
  assign ram_we    = in_accept && enq_ok;
  assign ram_waddr = slot_addr(lvl_idx, tail_q[lvl_idx]);
  assign ram_wdata = {in_data_i.task_function[HANDLE_BITS-1:0],
                      in_data_i.task_argument[HANDLE_BITS-1:0]};
  assign ram_re    = in_accept && deq_hit;
  assign ram_raddr = slot_addr(sel_lvl, head_q[sel_lvl]);

  spq_ram #(
    .Width (WordW),
    .Depth (Slots)
  ) u_task_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pointer and count updates happen at the accept edge.
  always_comb begin
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      head_d[l]  = head_q[l];
      tail_d[l]  = tail_q[l];
      count_d[l] = count_q[l];
      if (in_accept) begin
        if (is_flush) begin
          head_d[l]  = '0;
          tail_d[l]  = '0;
          count_d[l] = '0;
        end else if (enq_ok && (lvl_idx == LvlW'(l))) begin
          tail_d[l]  = wrap_inc(tail_q[l]);
          count_d[l] = count_q[l] + 1'b1;
        end else if (deq_hit && (sel_lvl == LvlW'(l))) begin
          head_d[l]  = wrap_inc(head_q[l]);
          count_d[l] = count_q[l] - 1'b1;
        end
      end
    end
  end

  // Result path: most results load at accept; a dequeue hit loads from the store next cycle.
  always_comb begin
    state_d     = state_q;
    served_d    = served_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (deq_hit) begin
            state_d  = S_READ;
            served_d = sel_lvl;
          end else begin
            out_valid_d         = 1'b1;
            out_d.served_level  = '0;
            out_d.out_function  = '0;
            out_d.out_argument  = '0;
            priority if (is_flush) begin
              out_d.status = ST_FLUSH;
            end else if (enq_ok) begin
              out_d.status = ST_ENQ;
            end else if (is_enq) begin
              out_d.status = ST_DROP;
            end else begin
              out_d.status = ST_EMPTY;
            end
          end
        end
      end
      S_READ: begin
        state_d            = S_IDLE;
        out_valid_d        = 1'b1;
        out_d.status       = ST_DEQ;
        out_d.served_level = 2'(served_q);
        out_d.out_function = FieldW'(ram_rdata[WordW-1:HANDLE_BITS]);
        out_d.out_argument = FieldW'(ram_rdata[HANDLE_BITS-1:0]);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    served_q <= served_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The output slot is always free while the store read is pending.
  `SPQ_ASSERT_IMPL(a_read_slot_free, state_q == S_READ, !out_valid_q)

  // A flush leaves every level empty.
  `SPQ_ASSERT_NEXT(a_flush_clears, in_accept && is_flush, level_nonempty == '0)

  // No result appears without a transaction behind it.
  `SPQ_ASSERT_NEXT(a_no_spurious_out, !in_accept && state_q == S_IDLE && !out_valid_q,
    !out_valid_q)

  // No level ever holds more than its depth.
  for (genvar g = 0; g < PRIO_LEVELS; g++) begin : g_cnt_chk
    `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q[g] <= CntW'(QUEUE_DEPTH))
  end

endmodule

// ===== tb/sv/spq_tb_pkg.sv =====
package spq_tb_pkg;
  import spq_pkg::*;

  localparam int unsigned PrioLevels = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned HandleBits = 32;

  // Mirror of the per-level task FIFOs plus the list of outcomes still owed.
  class task_queue_scoreboard;
    logic [2*FieldW-1:0] slot_mem [PrioLevels][QueueDepth];
    int unsigned head_idx [PrioLevels];
    int unsigned tail_idx [PrioLevels];
    int unsigned fill_cnt [PrioLevels];
    spq_out_t outcome_q [$];
    int unsigned errors;
    int unsigned status_cnt [8];

    function new();
      errors = 0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
      clear_levels();
    endfunction

    function void clear_levels();
      foreach (fill_cnt[l]) begin
        head_idx[l] = 0;
        tail_idx[l] = 0;
        fill_cnt[l] = 0;
      end
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // Expected result of one request; updates the mirrored FIFOs.
    function spq_out_t predict_outcome(spq_in_t req);
      spq_out_t res;
      logic [63:0] keep;
      int unsigned lvl;
      bit found;
      res = '0;
      res.status = ST_EMPTY;
      keep = (64'd1 << HandleBits) - 64'd1;
      lvl = req.priority_req;
      found = 1'b0;
      case (op_e'(req.func))
        OP_ENQ: begin
          if (lvl >= PrioLevels || fill_cnt[lvl] >= QueueDepth) begin
            res.status = ST_DROP;
          end else begin
            slot_mem[lvl][tail_idx[lvl]] = {req.task_function & keep[FieldW-1:0],
                                            req.task_argument & keep[FieldW-1:0]};
            tail_idx[lvl] = (tail_idx[lvl] + 1) % QueueDepth;
            fill_cnt[lvl]++;
            res.status = ST_ENQ;
          end
        end
        OP_DEQ: begin
          if (lvl < PrioLevels) begin
            for (int l = PrioLevels - 1; l >= int'(lvl); l--) begin
              if (!found && fill_cnt[l] > 0) begin
                found = 1'b1;
                {res.out_function, res.out_argument} = slot_mem[l][head_idx[l]];
                head_idx[l] = (head_idx[l] + 1) % QueueDepth;
                fill_cnt[l]--;
                res.served_level = 2'(l);
                res.status = ST_DEQ;
              end
            end
          end
        end
        OP_FLUSH: begin
          clear_levels();
          res.status = ST_FLUSH;
        end
        default: ;  // reserved op: no state change, nothing eligible
      endcase
      return res;
    endfunction

    function void note_request(spq_in_t req);
      spq_out_t res;
      res = predict_outcome(req);
      status_cnt[res.status]++;
      outcome_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [FieldW-1:0] want,
                                logic [FieldW-1:0] got, time stamp);
      if (want !== got) begin
        errors++;
        $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h", stamp, field, want, got);
      end
    endfunction

    function void check_outcome(spq_out_t got, time stamp);
      spq_out_t want;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected result, expected none, got 0x%0h", stamp, got);
      end else begin
        want = outcome_q.pop_front();
        compare_field("status", want.status, got.status, stamp);
        compare_field("served_level", want.served_level, got.served_level, stamp);
        compare_field("out_function", want.out_function, got.out_function, stamp);
        compare_field("out_argument", want.out_argument, got.out_argument, stamp);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int unsigned PhaseItems     = 458;   // random requests per idling phase
  localparam int unsigned BurstLen       = 48;    // requests per fill or drain burst
  localparam int unsigned LongHoldAt     = 1150;  // input count that starts the long hold
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 8;     // settling margin after the last phase
  localparam int unsigned WatchdogLimit  = 5000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  spq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  spq_out_t out_data_o;

  int unsigned send_idle_pct = 0;   // chance per cycle the sender holds back
  int unsigned recv_stall_pct = 0;  // chance per cycle the receiver stalls
  int unsigned taken_cnt = 0;       // input transactions accepted so far
  int unsigned quiet_cycles = 0;
  bit          long_hold_done = 1'b0;

  task_queue_scoreboard queue_mirror = new();

  always begin
    #6ns clk_i = ~clk_i;
  end

  strict_priority_task_queues #(
    .PRIO_LEVELS(PrioLevels),
    .QUEUE_DEPTH(QueueDepth),
    .HANDLE_BITS(HandleBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Monitors. Both channels are sampled at the edge where the transaction
  // happens; every driver updates with NBAs, so we see pre-edge values here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        queue_mirror.note_request(in_data_i);
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        queue_mirror.check_outcome(out_data_o, $time);
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("%0d ns: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. Random stalls per phase, plus one long hold-off while the sender
  // keeps offering, so the single result register backs up into in_stall_o.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && taken_cnt >= LongHoldAt) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic spq_in_t make_request(op_e op, logic [1:0] lvl,
                                           logic [FieldW-1:0] fn, logic [FieldW-1:0] arg);
    spq_in_t req;
    req.func          = op;
    req.priority_req  = lvl;
    req.task_function = fn;
    req.task_argument = arg;
    return req;
  endfunction

  // Handles and arguments: mostly random, with the all-zero and all-one corners.
  function automatic logic [FieldW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Bursts alternate between fill-heavy and drain-heavy. During a fill burst
  // most enqueues hit one hot level, so levels run full and pointers wrap.
  function automatic spq_in_t make_random_request(int unsigned idx, logic [1:0] hot);
    spq_in_t     req;
    int unsigned pick;
    int unsigned enq_pct;
    enq_pct = ((idx / BurstLen) % 2 == 0) ? 68 : 32;
    pick = $urandom_range(99);
    req = make_request(OP_DEQ, 2'($urandom_range(3)), rand_word(), rand_word());
    if (pick < 1) begin
      req.func = OP_FLUSH;
    end else if (pick < 3) begin
      req.func = OP_RSVD;
    end else if (pick < 3 + enq_pct) begin
      req.func = OP_ENQ;
      if ($urandom_range(99) < 60) req.priority_req = hot;
    end
    return req;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it; returns at the
  // edge where it was taken. Valid stays high into the next call if no gap.
  task automatic send_request(input spq_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender goes quiet until every owed result has come back.
  task automatic wait_all_served();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (queue_mirror.pending() != 0);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [1:0] hot;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hot = 2'($urandom_range(3));
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      if (i % BurstLen == 0) hot = 2'($urandom_range(3));
      send_request(make_random_request(i, hot));
    end
    wait_all_served();
  endtask

  task automatic run_directed();
    send_request(make_request(OP_DEQ, 2'd0, '0, '0));        // dequeue with all levels empty
    send_request(make_request(OP_RSVD, 2'd3, '1, '1));       // reserved op, must change nothing
    send_request(make_request(OP_ENQ, 2'd3, '1, '0));
    send_request(make_request(OP_ENQ, 2'd2, '0, '1));
    send_request(make_request(OP_ENQ, 2'd1, 32'hA5A5_5A5A, 32'h0123_4567));
    send_request(make_request(OP_DEQ, 2'd3, '0, '0));        // top level served first
    send_request(make_request(OP_DEQ, 2'd3, '0, '0));        // floor above the rest: empty
    send_request(make_request(OP_DEQ, 2'd0, '0, '0));        // level 2 before level 1
    send_request(make_request(OP_DEQ, 2'd2, '0, '0));        // only level 1 left, below floor
    send_request(make_request(OP_FLUSH, 2'd0, '0, '0));
    send_request(make_request(OP_DEQ, 2'd0, '0, '0));        // flush dropped level 1
    // fill level 0 to the brim (tail wraps), then one more gets dropped
    for (int unsigned i = 0; i <= QueueDepth; i++)
      send_request(make_request(OP_ENQ, 2'd0, rand_word(), rand_word()));
    wait_all_served();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random_phase(20, 81);  // sender mostly busy, receiver mostly stalled
    run_random_phase(81, 20);  // the reverse
    run_random_phase(0, 0);    // back to back; long receiver hold lands here
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d transactions: %0d enqueued, %0d dropped, %0d served,",
             taken_cnt, queue_mirror.status_cnt[ST_ENQ], queue_mirror.status_cnt[ST_DROP],
             queue_mirror.status_cnt[ST_DEQ]);
    $display("  %0d found nothing eligible, %0d flushes, under three stall mixes.",
             queue_mirror.status_cnt[ST_EMPTY], queue_mirror.status_cnt[ST_FLUSH]);
    if (queue_mirror.errors == 0 && queue_mirror.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
